>>> design/abv_pkg.sv
`default_nettype none

package abv_pkg;

  // Header layout: five little-endian 32-bit words ahead of the payload.
  localparam int unsigned HdrBytes = 20;
  localparam int unsigned IdxW     = 25;
  localparam int unsigned WordW    = 32;

  localparam logic [IdxW-1:0]  IdxMax         = {IdxW{1'b1}};
  localparam logic [IdxW-1:0]  SlotBytesReset = IdxW'(4096);
  localparam logic [WordW-1:0] CrcPoly        = 32'hEDB8_8320;
  localparam logic [WordW-1:0] CrcInit        = 32'hFFFF_FFFF;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegMagic     = 2'd0;
  localparam logic [1:0] RegType      = 2'd1;
  localparam logic [1:0] RegSlotBytes = 2'd2;

  // Verdict and version kept for both slots.
  typedef struct packed {
    logic             a_valid;
    logic [WordW-1:0] a_version;
    logic             b_valid;
    logic [WordW-1:0] b_version;
  } slot_state_t;

  // Selection derived from the slot state.
  typedef struct packed {
    logic             found;
    logic             best_slot;
    logic [WordW-1:0] best_version;
    logic             target_slot;
    logic [WordW-1:0] next_version;
  } select_t;

  // One byte of a reflected CRC-32.
  function automatic logic [WordW-1:0] crc32_byte(input logic [WordW-1:0] crc,
                                                  input logic [7:0] data);
    logic [WordW-1:0] r;
    r = crc ^ {24'b0, data};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/abv_slot_select.sv
`default_nettype none

module abv_slot_select (
  input  wire abv_pkg::slot_state_t state_i,
  output abv_pkg::select_t          sel_o
);
  import abv_pkg::*;

  logic             a_wins;
  logic             a_older;
  logic             best_slot;
  logic [WordW-1:0] best_version;
  logic             target_slot;

  assign a_wins  = state_i.a_version >= state_i.b_version;
  assign a_older = state_i.a_version <= state_i.b_version;

  always_comb begin
    priority if (state_i.a_valid && state_i.b_valid) begin
      best_slot    = !a_wins;
      best_version = a_wins ? state_i.a_version : state_i.b_version;
    end else if (state_i.a_valid) begin
      best_slot    = 1'b0;
      best_version = state_i.a_version;
    end else if (state_i.b_valid) begin
      best_slot    = 1'b1;
      best_version = state_i.b_version;
    end else begin
      best_slot    = 1'b0;
      best_version = '0;
    end
  end

  // An invalid slot is overwritten first, A before B; otherwise the older one.
  always_comb begin
    priority if (!state_i.a_valid) begin
      target_slot = 1'b0;
    end else if (!state_i.b_valid) begin
      target_slot = 1'b1;
    end else begin
      target_slot = !a_older;
    end
  end

  assign sel_o.found        = state_i.a_valid || state_i.b_valid;
  assign sel_o.best_slot    = best_slot;
  assign sel_o.best_version = best_version;
  assign sel_o.target_slot  = target_slot;
  assign sel_o.next_version = best_version + WordW'(1);

endmodule

`default_nettype wire

>>> design/ab_slot_record_validator.sv
// A result leaves on the master side once the last byte of a slot image has passed the
// input register, the processing stage and the result register. Throughput: one byte
// per cycle, set by the byte-wide CRC-32 update; a last byte stalls while a result is held.
// Reset (rst_ni low, asynchronous): pipeline empty, byte count zero, CRC all ones, both slots
// invalid with version zero, magic and type zero, slot size 4096 bytes.
`default_nettype none

module ab_slot_record_validator (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Slave side: one byte of a slot image per item.
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tuser,   // [0] slot_id
  input  wire logic         s_axis_tlast,   // last_byte
  // Master side: one item per finished slot image.
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [103:0] m_axis_tdata,   // [0] done_valid, [32:1] done_version,
                                            // [33] best_found, [34] best_slot,
                                            // [66:35] best_version, [67] target_slot,
                                            // [99:68] next_version, [103:100] zero
  output      logic         m_axis_tuser,   // [0] done_slot
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output      logic [31:0]  prdata,
  output      logic         pready
);
  import abv_pkg::*;

  // Header word positions.
  localparam int unsigned WMagic   = 0;
  localparam int unsigned WType    = 1;
  localparam int unsigned WVersion = 2;
  localparam int unsigned WLength  = 3;
  localparam int unsigned WCrc     = 4;

  // ---------------------------------------------------------------------------------------
  // Configuration registers. They must only be written while the block is idle; the block itself does not enforce this.
  // ---------------------------------------------------------------------------------------
  logic [WordW-1:0] magic_q;
  logic [WordW-1:0] type_q;
  logic [IdxW-1:0]  slot_bytes_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q      <= '0;
      type_q       <= '0;
      slot_bytes_q <= SlotBytesReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegMagic:     magic_q      <= pwdata;
        RegType:      type_q       <= pwdata;
        RegSlotBytes: slot_bytes_q <= pwdata[IdxW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegMagic:     prdata = magic_q;
      RegType:      prdata = type_q;
      RegSlotBytes: prdata = {{(WordW-IdxW){1'b0}}, slot_bytes_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Handshake between the three stages. Bytes that do not end an image produce no result,
  // so they pass the processing stage even while a result waits at the output. A last byte
  // moves on only when the pending stage is free or empties in the same cycle; this also
  // keeps the slot state in step with the pending result that the output stage reads.
  // ---------------------------------------------------------------------------------------
  logic in_v_q;
  logic in_slot_q;
  logic in_last_q;
  logic [7:0] in_byte_q;

  logic p_v_q;
  logic p_slot_q;
  logic p_ok_q;
  logic [WordW-1:0] p_ver_q;

  logic m_v_q;
  logic m_slot_q;
  logic [99:0] m_data_q;

  logic out_adv;
  logic p_move;
  logic p_free;
  logic proc_go;
  logic in_take;

  assign out_adv = !m_v_q || m_axis_tready;
  assign p_move  = p_v_q && out_adv;
  assign p_free  = !p_v_q || out_adv;
  assign proc_go = in_v_q && (!in_last_q || p_free);
  assign s_axis_tready = !in_v_q || proc_go;
  assign in_take = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_slot_q <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
      in_byte_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Processing stage: header capture, CRC over the payload, and the verdict on a last byte.
  // ---------------------------------------------------------------------------------------
  logic [IdxW-1:0]  byte_index_q;
  logic [WordW-1:0] crc_q;
  logic [4:0][WordW-1:0] hdr_q;
  slot_state_t      slots_q;

  logic             in_hdr;
  logic [IdxW-1:0]  pay_index;
  logic             crc_en;
  logic [WordW-1:0] crc_upd;
  logic [WordW-1:0] crc_d;
  logic [IdxW:0]    received;
  logic [WordW:0]   needed;
  logic [IdxW-1:0]  limit;
  logic             ok;
  logic [WordW-1:0] done_ver;

  assign in_hdr    = byte_index_q < IdxW'(HdrBytes);
  assign pay_index = byte_index_q - IdxW'(HdrBytes);
  // Payload bytes count from the end of the header; a saturated index stops the CRC.
  assign crc_en    = !in_hdr && (byte_index_q != IdxMax)
                     && ({{(WordW-IdxW){1'b0}}, pay_index} < hdr_q[WLength]);
  assign crc_upd   = crc32_byte(crc_q, in_byte_q);
  assign crc_d     = crc_en ? crc_upd : crc_q;

  // A last byte before the header and payload are complete fails the received-count check,
  // so header words left from an earlier image never make it valid.
  assign received = {1'b0, byte_index_q} + (IdxW+1)'(1);
  assign needed   = (WordW+1)'(HdrBytes) + {1'b0, hdr_q[WLength]};
  assign limit    = (slot_bytes_q >= IdxW'(HdrBytes)) ? slot_bytes_q - IdxW'(HdrBytes) : '0;

  assign ok = ({{(WordW-IdxW){1'b0}}, received} >= needed)
              && (hdr_q[WMagic] == magic_q)
              && (hdr_q[WType] == type_q)
              && (hdr_q[WLength] != '0)
              && (hdr_q[WLength] <= {{(WordW-IdxW){1'b0}}, limit})
              && (~crc_d == hdr_q[WCrc]);
  assign done_ver = ok ? hdr_q[WVersion] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      crc_q        <= CrcInit;
      slots_q      <= '0;
    end else if (proc_go) begin
      if (in_last_q) begin
        byte_index_q <= '0;
        crc_q        <= CrcInit;
        if (in_slot_q) begin
          slots_q.b_valid   <= ok;
          slots_q.b_version <= done_ver;
        end else begin
          slots_q.a_valid   <= ok;
          slots_q.a_version <= done_ver;
        end
      end else begin
        crc_q <= crc_d;
        if (byte_index_q != IdxMax) begin
          byte_index_q <= byte_index_q + IdxW'(1);
        end
      end
    end
  end

  // Header words hold whatever was last written; a fresh image of at least HdrBytes bytes rewrites them all.
  always_ff @(posedge clk_i) begin
    if (proc_go && in_hdr) begin
      hdr_q[byte_index_q[4:2]][8*byte_index_q[1:0] +: 8] <= in_byte_q;
    end
  end

  // Pending result of the slot just judged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (proc_go && in_last_q) begin
      p_v_q <= 1'b1;
    end else if (p_move) begin
      p_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && in_last_q) begin
      p_slot_q <= in_slot_q;
      p_ok_q   <= ok;
      p_ver_q  <= done_ver;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result register: the selection of best and target slot is taken from the slot state,
  // which at the moment of the move holds exactly the update of the pending result.
  // ---------------------------------------------------------------------------------------
  select_t sel;

  abv_slot_select u_select (
    .state_i (slots_q),
    .sel_o   (sel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (out_adv) begin
      m_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_move) begin
      m_slot_q <= p_slot_q;
      m_data_q <= {sel.next_version, sel.target_slot, sel.best_version,
                   sel.best_slot, sel.found, p_ver_q, p_ok_q};
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tuser  = m_slot_q;
  assign m_axis_tdata  = {4'b0, m_data_q};

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import abv_pkg::*;

  // Run length and timing knobs.
  localparam int unsigned RandomItems = 2000;  // bytes offered in the random phases
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned HoldCycles = 400;    // long receiver hold-off
  localparam int unsigned DrainCycles = 8;     // margin after the last verdict
  localparam int unsigned LimitCycles = 400000;

  // Register index that decodes to nothing; writes to it must be dropped.
  localparam int unsigned RegUnused = 3;

  // One byte on the slave side.
  typedef struct packed {
    logic       sid;
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // One verdict on the master side, in the order of the work fields.
  typedef struct packed {
    logic             done_slot;
    logic             done_valid;
    logic [WordW-1:0] done_version;
    logic             best_found;
    logic             best_slot;
    logic [WordW-1:0] best_version;
    logic             target_slot;
    logic [WordW-1:0] next_version;
  } verdict_t;

  // Shapes of slot image that the stimulus can produce.
  typedef enum {
    IMG_GOOD,
    IMG_BAD_MAGIC,
    IMG_BAD_TYPE,
    IMG_ZERO_LEN,
    IMG_LONG_LEN,
    IMG_BAD_CRC,
    IMG_EARLY_END,
    IMG_NOISE
  } image_kind_e;

  // Predicts the verdict of every finished slot image and holds the verdicts
  // that have not come out of the block yet.
  class slot_verdict_scoreboard;
    bit [WordW-1:0] magic;
    bit [WordW-1:0] rtype;
    bit [IdxW-1:0]  slot_bytes;
    bit [IdxW-1:0]  index;
    bit [WordW-1:0] hdr [5];  // magic, type, version, length, crc
    bit [WordW-1:0] crc;
    bit             a_valid;
    bit [WordW-1:0] a_version;
    bit             b_valid;
    bit [WordW-1:0] b_version;
    verdict_t       verdicts [$];
    int unsigned    errors;

    function new();
      magic      = '0;
      rtype      = '0;
      slot_bytes = SlotBytesReset;
      index      = '0;
      foreach (hdr[k]) hdr[k] = '0;
      crc        = CrcInit;
      a_valid    = 1'b0;
      a_version  = '0;
      b_valid    = 1'b0;
      b_version  = '0;
      errors     = 0;
    endfunction

    // Reflected CRC-32, one data bit at a time.
    static function bit [WordW-1:0] crc_byte(bit [WordW-1:0] c, bit [7:0] d);
      bit fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ d[i];
        c  = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    // Largest payload length that fits in one slot.
    function bit [WordW-1:0] slot_limit();
      return (slot_bytes >= HdrBytes) ? {7'b0, slot_bytes} - WordW'(HdrBytes) : '0;
    endfunction

    function void write_reg(int unsigned reg_index, bit [WordW-1:0] value);
      if (reg_index == RegMagic) magic = value;
      else if (reg_index == RegType) rtype = value;
      else if (reg_index == RegSlotBytes) slot_bytes = value[IdxW-1:0];
    endfunction

    function int unsigned pending();
      return verdicts.size();
    endfunction

    // Called for every byte that the block accepts.
    function void note_byte(bit sid, bit [7:0] data, bit last);
      bit [IdxW-1:0] at;
      bit [32:0]     received;
      bit            ok;
      verdict_t      v;
      at = index;
      if (at < HdrBytes) begin
        hdr[at >> 2][8*at[1:0] +: 8] = data;
      end else if (at != IdxMax && ({7'b0, at} - WordW'(HdrBytes)) < hdr[3]) begin
        crc = crc_byte(crc, data);
      end
      if (at != IdxMax) index = at + 1'b1;
      if (!last) return;

      received = {8'b0, at} + 33'd1;
      ok = (received >= 33'(HdrBytes) + {1'b0, hdr[3]})
           && hdr[0] == magic && hdr[1] == rtype
           && hdr[3] != '0 && hdr[3] <= slot_limit()
           && ~crc == hdr[4];
      if (sid == 1'b0) begin
        a_valid   = ok;
        a_version = ok ? hdr[2] : '0;
      end else begin
        b_valid   = ok;
        b_version = ok ? hdr[2] : '0;
      end
      index = '0;
      crc   = CrcInit;

      v.done_slot    = sid;
      v.done_valid   = ok;
      v.done_version = ok ? hdr[2] : '0;
      v.best_found   = a_valid || b_valid;
      if (a_valid && b_valid) v.best_slot = (a_version >= b_version) ? 1'b0 : 1'b1;
      else v.best_slot = !a_valid && b_valid;
      if (!v.best_found) v.best_version = '0;
      else v.best_version = v.best_slot ? b_version : a_version;
      if (!a_valid) v.target_slot = 1'b0;
      else if (!b_valid) v.target_slot = 1'b1;
      else v.target_slot = (a_version <= b_version) ? 1'b0 : 1'b1;
      v.next_version = v.best_version + 1'b1;
      verdicts.push_back(v);
    endfunction

    function void check_field(string name, bit [WordW-1:0] exp, logic [WordW-1:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
        errors++;
      end
    endfunction

    // Called for every verdict that leaves the block.
    function void check_verdict(logic tuser, logic [103:0] tdata);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $display("%0t: verdict with none expected, expected nothing, got %h / %h",
                 $time, tuser, tdata);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      check_field("done_slot", v.done_slot, tuser);
      check_field("done_valid", v.done_valid, tdata[0]);
      check_field("done_version", v.done_version, tdata[32:1]);
      check_field("best_found", v.best_found, tdata[33]);
      check_field("best_slot", v.best_slot, tdata[34]);
      check_field("best_version", v.best_version, tdata[66:35]);
      check_field("target_slot", v.target_slot, tdata[67]);
      check_field("next_version", v.next_version, tdata[99:68]);
    endfunction
  endclass

  // Clock, reset and block ports. Every input has a known value from time zero.
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // [7:0] data_byte
  logic         s_axis_tuser = 1'b0; // [0] slot_id
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // [0] done_valid, [32:1] done_version, [33] best_found,
                                     // [34] best_slot, [66:35] best_version,
                                     // [67] target_slot, [99:68] next_version
  logic         m_axis_tuser;        // [0] done_slot
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  slot_verdict_scoreboard sb;
  byte_item_t   image_q [$];   // bytes of the image about to be sent
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;

  // Idle controls shared between the stimulus and the two handshake sides.
  bit send_idle_off = 1'b0;
  bit recv_idle_off = 1'b0;
  bit hold_request = 1'b0;

  ab_slot_record_validator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Monitors. Everything the testbench drives changes through nonblocking
  // assignments, so at the edge both sides see the values from before it.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_byte(s_axis_tuser, s_axis_tdata, s_axis_tlast);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_verdict(m_axis_tuser, m_axis_tdata);
    end
  end

  // Receiver. Before each verdict it draws a random stall; on request
  // it holds off for a long stretch so that the block backs up to its input.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HoldCycles;
      end else begin
        stall = recv_idle_off ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        for (int c = 0; c < stall; c++) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offers one byte after a random gap and returns at the edge that takes it.
  // tvalid stays high into the next byte when that byte has no gap.
  task automatic push_byte(input byte_item_t item);
    int unsigned gap;
    gap = send_idle_off ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item.data;
    s_axis_tuser  <= item.sid;
    s_axis_tlast  <= item.last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // One APB transfer: setup phase, then access phase until pready, then back to idle.
  task automatic apb_transfer(input bit write, input int unsigned reg_index,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= 4'(reg_index * 4);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes a register, mirrors it in the predictor and, for a decoded index, reads it back.
  task automatic program_reg(input int unsigned reg_index, input logic [31:0] value);
    logic [31:0] readback;
    apb_transfer(1'b1, reg_index, value, readback);
    sb.write_reg(reg_index, value);
    if (reg_index <= RegSlotBytes) begin
      apb_transfer(1'b0, reg_index, '0, readback);
      sb.check_field("register readback",
                     (reg_index == RegSlotBytes) ? {7'b0, value[IdxW-1:0]} : value,
                     readback);
    end
  endtask

  // Stops offering bytes and waits until every verdict has come out, plus the
  // pipeline latency, so that registers may be changed safely. The first edge
  // lets the monitor note the byte taken at the edge where the caller resumed.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Builds the bytes of one slot image against the current register values.
  // plen is the payload length written to the header.
  function automatic void build_image(input image_kind_e kind, input bit sid,
                                      input bit [WordW-1:0] version,
                                      input int unsigned plen);
    bit [WordW-1:0] words [5];
    bit [7:0]       payload [$];
    bit [7:0]       stream [$];
    bit [7:0]       b;
    bit [WordW-1:0] fold;
    bit [WordW-1:0] limit;
    int unsigned    sent;
    int unsigned    total;
    bit             wander;
    byte_item_t     item;
    limit = sb.slot_limit();
    // An oversized length: one to three bytes past a limit under 200, else one byte past,
    // so that only the length check fails; for a length over 300 the image also ends early.
    if (kind == IMG_LONG_LEN) plen = limit + 1 + ((limit < 200) ? $urandom_range(0, 2) : 0);
    sent = (plen > 300) ? 64 : plen;
    fold = CrcInit;
    for (int k = 0; k < sent; k++) begin
      b = $urandom;
      payload.push_back(b);
      fold = slot_verdict_scoreboard::crc_byte(fold, b);
    end
    words[0] = sb.magic;
    words[1] = sb.rtype;
    words[2] = version;
    words[3] = plen;
    words[4] = ~fold;
    case (kind)
      IMG_BAD_MAGIC: words[0] ^= 32'd1 << $urandom_range(0, 31);
      IMG_BAD_TYPE:  words[1] ^= 32'd1 << $urandom_range(0, 31);
      IMG_BAD_CRC:   words[4] ^= 32'd1 << $urandom_range(0, 31);
      IMG_ZERO_LEN: begin
        // The CRC over no bytes is zero, so only the length is wrong.
        words[3] = '0;
        words[4] = '0;
      end
      default: ;
    endcase
    for (int k = 0; k < HdrBytes; k++) stream.push_back(words[k / 4][8*(k % 4) +: 8]);
    stream = {stream, payload};
    // Bytes after the payload are ignored by the block.
    repeat ($urandom_range(0, 3)) stream.push_back(8'($urandom));
    if (kind == IMG_EARLY_END) begin
      total = $urandom_range(1, HdrBytes + plen - 1);
      while (stream.size() > total) void'(stream.pop_back());
    end
    if (kind == IMG_NOISE) begin
      stream = {};
      repeat ($urandom_range(1, 30)) stream.push_back(8'($urandom));
    end
    // Now and then the slot id wanders inside the image; only the last byte counts.
    wander = ($urandom_range(0, 7) == 0);
    image_q = {};
    foreach (stream[k]) begin
      item.data = stream[k];
      item.last = (k == stream.size() - 1);
      item.sid  = (wander && !item.last) ? 1'($urandom_range(0, 1)) : sid;
      image_q.push_back(item);
    end
  endfunction

  task automatic run_image(input image_kind_e kind, input bit sid,
                           input bit [WordW-1:0] version, input int unsigned plen);
    build_image(kind, sid, version, plen);
    foreach (image_q[k]) push_byte(image_q[k]);
    items_sent += image_q.size();
  endtask

  // Random image: mostly well formed, with versions chosen to hit ties, wraps
  // and ordering between the two slots.
  task automatic random_image();
    bit             sid;
    bit [WordW-1:0] other;
    bit [WordW-1:0] version;
    bit [WordW-1:0] limit;
    int unsigned    cap;
    int unsigned    plen;
    int unsigned    r;
    image_kind_e    kind;
    sid   = $urandom_range(0, 1);
    other = sid ? sb.a_version : sb.b_version;
    case ($urandom_range(0, 9))
      0:       version = '0;
      1:       version = '1;
      2:       version = other;
      3:       version = other + 1'b1;
      default: version = $urandom;
    endcase
    limit = sb.slot_limit();
    cap   = (limit < 40) ? limit : 40;
    plen  = $urandom_range(1, cap);
    if ($urandom_range(0, 9) == 0) plen = (limit <= 300) ? limit : $urandom_range(41, 300);
    r = $urandom_range(0, 99);
    if (r < 55) kind = IMG_GOOD;
    else if (r < 61) kind = IMG_BAD_MAGIC;
    else if (r < 66) kind = IMG_BAD_TYPE;
    else if (r < 70) kind = IMG_ZERO_LEN;
    else if (r < 75) kind = IMG_LONG_LEN;
    else if (r < 81) kind = IMG_BAD_CRC;
    else if (r < 90) kind = IMG_EARLY_END;
    else kind = IMG_NOISE;
    run_image(kind, sid, version, plen);
  endtask

  // Register settings for one random phase; slot size sweeps the extremes.
  task automatic configure_phase(input int unsigned phase);
    logic [31:0] magic;
    logic [31:0] rtype;
    logic [31:0] sbytes;
    magic = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
    rtype = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
    case (phase % 6)
      0:       sbytes = 21;
      1:       sbytes = $urandom_range(22, 80);
      2:       sbytes = 4096;
      3:       sbytes = $urandom_range(21, 32'h100_0000);
      4:       sbytes = 32'h100_0000;
      default: sbytes = $urandom_range(21, 60);
    endcase
    program_reg(RegMagic, magic);
    program_reg(RegType, rtype);
    program_reg(RegSlotBytes, sbytes);
    if (phase == RandomPhases - 1) program_reg(RegUnused, $urandom);
  endtask

  initial begin : stimulus
    int unsigned base;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first with the reset register values. The first image
    // carries a full header so that no header word is read before written.
    run_image(IMG_GOOD, 1'b0, 32'd5, 1);
    run_image(IMG_EARLY_END, 1'b1, 32'd9, 1);
    wait_idle();

    // Smallest slot: one payload byte fits, two do not. Magic and type all ones.
    program_reg(RegMagic, '1);
    program_reg(RegType, '1);
    program_reg(RegSlotBytes, 21);
    program_reg(RegUnused, 32'h0000_0033);
    run_image(IMG_GOOD, 1'b1, '1, 1);        // next version wraps to zero
    run_image(IMG_LONG_LEN, 1'b0, 32'd7, 1);
    run_image(IMG_GOOD, 1'b0, '1, 1);        // equal versions: A wins, A is target
    run_image(IMG_BAD_CRC, 1'b1, 32'd3, 1);
    run_image(IMG_ZERO_LEN, 1'b0, 32'd4, 1);
    wait_idle();

    // Largest slot, zero magic.
    program_reg(RegMagic, '0);
    program_reg(RegType, 32'h5AA5_0FF0);
    program_reg(RegSlotBytes, 32'h100_0000);
    run_image(IMG_GOOD, 1'b1, 32'h8000_0000, 3);
    run_image(IMG_BAD_MAGIC, 1'b0, 32'd1, 2);
    run_image(IMG_BAD_TYPE, 1'b1, 32'd2, 2);
    run_image(IMG_NOISE, 1'b0, 32'd0, 1);

    // Random phases. One runs with no idling at all; one has the receiver hold
    // off for a long stretch while the sender keeps offering bytes.
    base = items_sent;
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      configure_phase(phase);
      send_idle_off = (phase == 2) || (phase == 3);
      recv_idle_off = (phase == 2);
      hold_request  = (phase == 3);
      while (items_sent < base + (phase + 1) * RandomItems / RandomPhases) random_image();
    end
    send_idle_off = 1'b0;
    recv_idle_off = 1'b0;

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
design/abv_pkg.sv
design/abv_slot_select.sv
design/ab_slot_record_validator.sv
tb/sv/tb.sv
